// ----- design/mfba_pkg.sv -----
package mfba_pkg;

    localparam int DEF_NUM_BUFFERS = 1024;
    localparam int DEF_NUM_LISTS   = 8;
    localparam int DEF_NUM_POOLS   = 3;

    localparam int FUNC_W   = 1;
    localparam int POOL_W   = 2;
    localparam int HINT_W   = 3;
    localparam int BIDX_W   = 10;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 10;
    localparam int USED_W   = 11;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ALLOC   = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FREED   = 2'd2,
        STAT_IGNORED = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic init_step;
        logic capture;
        logic lookup;
        logic commit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic init_done;
        logic out_free;
    } sts_t;

endpackage

// ----- design/mfba_ram.sv -----
module mfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mfba_ctrl.sv -----
module mfba_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mfba_pkg::sts_t sts,
    output mfba_pkg::cmd_t cmd
);
    import mfba_pkg::*;

    typedef enum logic [3:0] {
        S_INIT   = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOKUP = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // hold until the result register can take the answer
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

// ----- design/mfba_dp.sv -----
module mfba_dp #(
    parameter int NUM_BUFFERS = mfba_pkg::DEF_NUM_BUFFERS,
    parameter int NUM_LISTS   = mfba_pkg::DEF_NUM_LISTS,
    parameter int NUM_POOLS   = mfba_pkg::DEF_NUM_POOLS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mfba_pkg::cmd_t                cmd,
    output mfba_pkg::sts_t                sts,
    input  logic [mfba_pkg::FUNC_W-1:0]   s_func,
    input  logic [mfba_pkg::POOL_W-1:0]   s_pool_kind,
    input  logic [mfba_pkg::HINT_W-1:0]   s_list_hint,
    input  logic [mfba_pkg::BIDX_W-1:0]   s_buffer_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mfba_pkg::STATUS_W-1:0] m_status,
    output logic [mfba_pkg::GRANT_W-1:0]  m_granted_index,
    output logic [mfba_pkg::USED_W-1:0]   m_used_count
);
    import mfba_pkg::*;

    localparam int BW     = $clog2(NUM_BUFFERS);
    localparam int LW     = $clog2(NUM_BUFFERS + 1);
    localparam int LSW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PW     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int R      = NUM_BUFFERS / NUM_LISTS;
    localparam int RPW    = (R > 1) ? $clog2(R) : 1;
    localparam int DEPTH  = NUM_POOLS * NUM_BUFFERS;
    localparam int AW     = $clog2(DEPTH);
    localparam int EW     = LW + 1;
    localparam int UNEVEN = NUM_BUFFERS - NUM_LISTS * R;

    localparam logic [LW-1:0]  NONE_MARK   = LW'(NUM_BUFFERS);
    localparam logic [AW-1:0]  POOL_STRIDE = AW'(NUM_BUFFERS);
    localparam logic [LSW:0]   LIST_COUNT  = (LSW + 1)'(NUM_LISTS);

    // request registers
    logic [FUNC_W-1:0] func_reg;
    logic [POOL_W-1:0] pool_reg;
    logic [HINT_W-1:0] hint_reg;
    logic [BIDX_W-1:0] bidx_reg;

    // list heads and used counts
    logic [LW-1:0] head_reg [NUM_POOLS][NUM_LISTS];
    logic [LW-1:0] used_reg [NUM_POOLS];

    // lookup stage registers
    logic [LSW-1:0] l_sel_reg;
    logic [LW-1:0]  head_sel_reg;
    logic           found_reg;
    logic [BW-1:0]  idx_reg;
    logic [AW-1:0]  addr_reg;

    // reset sweep counters
    logic [AW-1:0]  init_addr_reg;
    logic [BW-1:0]  init_b_reg;
    logic [RPW-1:0] init_pos_reg;

    // result register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [GRANT_W-1:0]  m_granted_reg;
    logic [USED_W-1:0]   m_used_reg;

    logic           pool_ok;
    logic [PW-1:0]  pool_sel;
    logic           bidx_ok;
    logic           is_alloc;
    logic [LW-1:0]  pool_heads [NUM_LISTS];
    logic [NUM_LISTS-1:0]   nonempty;
    logic [2*NUM_LISTS-1:0] doubled;
    logic [NUM_LISTS-1:0]   rot;
    logic [LSW-1:0] start;
    logic [LSW-1:0] off;
    logic           found;
    logic [LSW:0]   sum;
    logic [LSW-1:0] l_alloc;
    logic [31:0]    scaled;
    logic [LSW-1:0] l_free;
    logic [LSW-1:0] l_pick;
    logic [LW-1:0]  head_pick;
    logic [BW-1:0]  idx_pick;
    logic [AW-1:0]  rd_addr;

    logic [EW-1:0]  rd_data;
    logic           rd_on;
    logic [LW-1:0]  rd_link;
    logic           do_alloc;
    logic           do_free;
    status_t        status_next;
    logic [LW-1:0]  used_cur;
    logic [LW-1:0]  used_next;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [EW-1:0]  wr_data;

    logic           init_on;
    logic           init_last;
    logic           init_b_last;
    logic [LW-1:0]  init_link;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            pool_reg <= s_pool_kind;
            hint_reg <= s_list_hint;
            bidx_reg <= s_buffer_index;
        end
    end

    assign pool_ok  = (32'(pool_reg) < 32'(NUM_POOLS));
    assign pool_sel = pool_ok ? PW'(pool_reg) : '0;
    assign bidx_ok  = (32'(bidx_reg) < 32'(NUM_BUFFERS));
    assign is_alloc = (func_reg == FUNC_ALLOC);

    always_comb begin
        for (int l = 0; l < NUM_LISTS; l++) begin
            pool_heads[l] = head_reg[pool_sel][l];
            nonempty[l]   = (pool_heads[l] != NONE_MARK);
        end
    end

    // starting list: hint modulo list count
    always_comb begin
        start = '0;
        for (int k = 0; k < (1 << HINT_W); k++) begin
            if (hint_reg == HINT_W'(k)) begin
                start = LSW'(k % NUM_LISTS);
            end
        end
    end

    assign doubled = {nonempty, nonempty} >> start;
    assign rot     = doubled[NUM_LISTS-1:0];
    assign found   = |rot;

    always_comb begin
        off = '0;
        for (int i = NUM_LISTS - 1; i >= 0; i--) begin
            if (rot[i]) begin
                off = LSW'(i);
            end
        end
    end

    assign sum     = {1'b0, start} + {1'b0, off};
    assign l_alloc = (sum >= LIST_COUNT) ? LSW'(sum - LIST_COUNT) : LSW'(sum);

    // owning list of a returned buffer: floor(index * lists / buffers)
    assign scaled = 32'(bidx_reg) * 32'(NUM_LISTS);

    always_comb begin
        l_free = '0;
        for (int k = 1; k < NUM_LISTS; k++) begin
            if (scaled >= 32'(k * NUM_BUFFERS)) begin
                l_free = LSW'(k);
            end
        end
    end

    assign l_pick    = is_alloc ? l_alloc : l_free;
    assign head_pick = pool_heads[l_pick];
    assign idx_pick  = is_alloc ? BW'(head_pick) : BW'(bidx_reg);
    assign rd_addr   = AW'(pool_sel) * POOL_STRIDE + AW'(idx_pick);

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            l_sel_reg    <= l_pick;
            head_sel_reg <= head_pick;
            found_reg    <= found;
            idx_reg      <= idx_pick;
            addr_reg     <= rd_addr;
        end
    end

    assign rd_on    = rd_data[LW];
    assign rd_link  = rd_data[LW-1:0];
    assign do_alloc = pool_ok && is_alloc && found_reg;
    assign do_free  = pool_ok && !is_alloc && bidx_ok && !rd_on;
    assign used_cur = used_reg[pool_sel];

    always_comb begin
        priority if (!pool_ok) begin
            status_next = is_alloc ? STAT_EMPTY : STAT_IGNORED;
        end else if (is_alloc) begin
            status_next = found_reg ? STAT_ALLOC : STAT_EMPTY;
        end else begin
            status_next = do_free ? STAT_FREED : STAT_IGNORED;
        end
    end

    always_comb begin
        used_next = used_cur;
        if (do_alloc && (used_cur < NONE_MARK)) begin
            used_next = used_cur + LW'(1);
        end else if (do_free && (used_cur != '0)) begin
            used_next = used_cur - LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_POOLS; p++) begin
                used_reg[p] <= LW'(UNEVEN);
                for (int l = 0; l < NUM_LISTS; l++) begin
                    head_reg[p][l] <= (R == 0) ? NONE_MARK : LW'(l * R);
                end
            end
        end else if (cmd.commit) begin
            if (do_alloc) begin
                head_reg[pool_sel][l_sel_reg] <= rd_link;
            end else if (do_free) begin
                head_reg[pool_sel][l_sel_reg] <= LW'(idx_reg);
            end
            if (pool_ok) begin
                used_reg[pool_sel] <= used_next;
            end
        end
    end

    // reset sweep: chain each list's range, mark leftovers as used
    assign init_on     = (32'(init_b_reg) < 32'(NUM_LISTS * R));
    assign init_last   = (init_pos_reg == RPW'(R - 1));
    assign init_b_last = (init_b_reg == BW'(NUM_BUFFERS - 1));
    assign init_link   = (init_on && !init_last) ? LW'(init_b_reg) + LW'(1) : NONE_MARK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_addr_reg <= '0;
            init_b_reg    <= '0;
            init_pos_reg  <= '0;
        end else if (cmd.init_step) begin
            init_addr_reg <= init_addr_reg + AW'(1);
            init_b_reg    <= init_b_last ? '0 : init_b_reg + BW'(1);
            init_pos_reg  <= (init_b_last || init_last) ? '0 : init_pos_reg + RPW'(1);
        end
    end

    assign sts.init_done = (init_addr_reg == AW'(DEPTH - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        wr_en   = cmd.init_step || (cmd.commit && (do_alloc || do_free));
        wr_addr = cmd.init_step ? init_addr_reg : addr_reg;
        if (cmd.init_step) begin
            wr_data = {init_on, init_link};
        end else if (do_alloc) begin
            wr_data = {1'b0, NONE_MARK};
        end else begin
            wr_data = {1'b1, head_sel_reg};
        end
    end

    mfba_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.lookup),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg  <= status_next;
            m_granted_reg <= do_alloc ? GRANT_W'(idx_reg) : '0;
            m_used_reg    <= pool_ok ? USED_W'(used_next) : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_index = m_granted_reg;
    assign m_used_count    = m_used_reg;

endmodule

// ----- design/multi_freelist_buffer_allocator.sv -----
// Order: a request transfer is followed by the lookup step, then the commit step that registers
//   the result. Requests are taken one at a time, since s_ready is high only in idle; the next-link
//   RAM is read in lookup and written in commit, and a result stalled on m_ready holds the commit step.
// Reset: synchronous, active-low aresetn. After release the next-link RAM is swept once over
//   all NUM_POOLS*NUM_BUFFERS entries (3072 at defaults), with s_ready low throughout.
module multi_freelist_buffer_allocator #(
    parameter int NUM_BUFFERS = mfba_pkg::DEF_NUM_BUFFERS,
    parameter int NUM_LISTS   = mfba_pkg::DEF_NUM_LISTS,
    parameter int NUM_POOLS   = mfba_pkg::DEF_NUM_POOLS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mfba_pkg::FUNC_W-1:0]   s_func,
    input  logic [mfba_pkg::POOL_W-1:0]   s_pool_kind,
    input  logic [mfba_pkg::HINT_W-1:0]   s_list_hint,
    input  logic [mfba_pkg::BIDX_W-1:0]   s_buffer_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mfba_pkg::STATUS_W-1:0] m_status,
    output logic [mfba_pkg::GRANT_W-1:0]  m_granted_index,
    output logic [mfba_pkg::USED_W-1:0]   m_used_count
);
    import mfba_pkg::*;

    // Command and status between the sequencer and the datapath. The sequencer
    // steps init sweep -> idle -> lookup -> commit; the datapath owns the list
    // heads, the per-pool used counts, the next-link RAM and the result register.
    cmd_t cmd;
    sts_t sts;

    // Sequencer: take one request per pass, hold commit while the result
    // register is still occupied.
    mfba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: lookup picks the list (the first non-empty one scanning circularly from the hint
    // for an allocate, the owning range for a return) and reads the buffer's link
    // word; commit pops or pushes the head and updates the used count.
    mfba_dp #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .NUM_LISTS   (NUM_LISTS),
        .NUM_POOLS   (NUM_POOLS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_func          (s_func),
        .s_pool_kind     (s_pool_kind),
        .s_list_hint     (s_list_hint),
        .s_buffer_index  (s_buffer_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_used_count    (m_used_count)
    );

`ifndef ASSERT_OFF
    // one request in flight: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // no grant index unless a buffer was allocated
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_ALLOC)) |-> (m_granted_index == '0))
        else $error("granted index set without allocation");

    // an allocation leaves at least one buffer in use
    a_alloc_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_ALLOC)) |-> (m_used_count != '0))
        else $error("allocation reported with zero used count");

    // used count never exceeds the pool size
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_used_count) <= 32'(NUM_BUFFERS)))
        else $error("used count above pool size");
`endif

endmodule
